[sv/bpa_pkg.sv]
// Shared types, codes and helpers for the button press autorepeat block.
package bpa_pkg;

   // Field widths of the request and response words.
   localparam int OP_W     = 2;
   localparam int ACTION_W = 3;
   localparam int MASK_W   = 8;
   localparam int TIME_W   = 32;
   localparam int CFG_W    = 16;
   localparam int CSR_IDX_W = 3;

   // Widest action index the block supports (up to 32 actions).
   localparam int IDX_W = 5;
   localparam int MASK_IDX_W = $clog2(MASK_W);

   // Default number of actions.
   localparam int ACTIONS_DEFAULT = 8;

   // Request operation codes.
   localparam logic [OP_W-1:0] OP_LATCH  = 2'd0;
   localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
   localparam logic [OP_W-1:0] OP_BLOCK  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_DELAY  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_INTERVAL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INTERVAL   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP           = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_MASK    = 3'd4;

   // Configuration values after reset.
   localparam logic [CFG_W-1:0]  INITIAL_DELAY_RESET  = 16'd320;
   localparam logic [CFG_W-1:0]  START_INTERVAL_RESET = 16'd120;
   localparam logic [CFG_W-1:0]  MIN_INTERVAL_RESET   = 16'd45;
   localparam logic [CFG_W-1:0]  RAMP_RESET           = 16'd1000;
   localparam logic [MASK_W-1:0] REPEAT_MASK_RESET    = 8'h0F;

   // Request from the sequencer to the interval unit.
   typedef struct packed {
      logic              start;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] since;
   } ival_req_type;

   // Answer of the interval unit.
   typedef struct packed {
      logic             done;
      logic [CFG_W-1:0] interval;
   } ival_rsp_type;

   // Bit of an 8-bit action mask; actions past the mask read as zero.
   function automatic logic mask_bit(input logic [MASK_W-1:0] m, input logic [IDX_W-1:0] i);
      logic r;
      r = 1'b0;
      if (i < IDX_W'(MASK_W)) begin
         r = m[i[MASK_IDX_W-1:0]];
      end
      return r;
   endfunction

endpackage

[sv/bpa_ram.sv]
// Generic single-port-write, registered-read RAM.
module bpa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/bpa_interval.sv]
// Repeat interval unit: clamp of the held time, one multiply and a 16-step divider.
module bpa_interval (
   input  logic                       clock,
   input  logic                       reset,
   input  bpa_pkg::ival_req_type      req,
   input  logic [bpa_pkg::CFG_W-1:0]  start_interval,
   input  logic [bpa_pkg::CFG_W-1:0]  min_interval,
   input  logic [bpa_pkg::CFG_W-1:0]  ramp,
   output bpa_pkg::ival_rsp_type      rsp
);

   localparam int W = bpa_pkg::CFG_W;
   localparam int CNT_W = $clog2(W);

   typedef enum logic [4:0] {
      P_IDLE = 5'b00001,
      P_MUL  = 5'b00010,
      P_LOAD = 5'b00100,
      P_DIV  = 5'b01000,
      P_DONE = 5'b10000
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [W-1:0]       hold_ff, hold_in;
   logic [W-1:0]       mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic               zero_ramp_ff, zero_ramp_in;
   logic [2*W-1:0]     prod_ff, prod_in;
   logic [W-1:0]       rem_ff, rem_in;
   logic [W-1:0]       quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic [bpa_pkg::TIME_W:0] held_diff;
   logic [W:0]               span;
   logic [W:0]               trial;
   logic [W:0]               sum;

   // Held time as a signed difference, clamped to [0, ramp].
   always_comb begin
      held_diff = {1'b0, req.now} - {1'b0, req.since};
      span      = {1'b0, min_interval} - {1'b0, start_interval};
   end

   // One restoring division step per cycle.
   always_comb begin
      trial = {rem_ff, quo_ff[W-1]};
   end

   // Sequencing of the unit.
   always_comb begin
      phase_in     = phase_ff;
      hold_in      = hold_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      zero_ramp_in = zero_ramp_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      case (phase_ff)
         P_IDLE: begin
            if (req.start) begin
               if (held_diff[bpa_pkg::TIME_W]) begin
                  hold_in = '0;
               end else if (held_diff[bpa_pkg::TIME_W-1:0] > bpa_pkg::TIME_W'(ramp)) begin
                  hold_in = ramp;
               end else begin
                  hold_in = held_diff[W-1:0];
               end
               neg_in       = span[W];
               mag_in       = span[W] ? W'(-span) : span[W-1:0];
               zero_ramp_in = (ramp == '0);
               phase_in     = P_MUL;
            end
         end
         P_MUL: begin
            prod_in  = mag_ff * hold_ff;
            phase_in = P_LOAD;
         end
         P_LOAD: begin
            // The quotient fits in W bits, so the upper half starts as the remainder.
            rem_in   = prod_ff[2*W-1:W];
            quo_in   = prod_ff[W-1:0];
            cnt_in   = CNT_W'(W - 1);
            phase_in = P_DIV;
         end
         P_DIV: begin
            if (trial >= {1'b0, ramp}) begin
               rem_in = W'(trial - {1'b0, ramp});
               quo_in = {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_in = trial[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               phase_in = P_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         P_DONE: begin
            phase_in = P_IDLE;
         end
         default: begin
            phase_in = P_IDLE;
         end
      endcase
   end

   // Signed quotient truncated toward zero, added to the start interval.
   always_comb begin
      sum = neg_ff ? ({1'b0, start_interval} - {1'b0, quo_ff})
                   : ({1'b0, start_interval} + {1'b0, quo_ff});
      rsp.done     = (phase_ff == P_DONE);
      rsp.interval = zero_ramp_ff ? min_interval : sum[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff      <= hold_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      zero_ramp_ff <= zero_ramp_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
   end

   // A finished interval is reported for exactly one cycle.
   assert property (@(posedge clock) disable iff (reset) rsp.done |=> !rsp.done)
      else $error("interval done held for more than one cycle");

   // The last division step is followed by the answer.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == P_DIV && cnt_ff == '0) |=> rsp.done)
      else $error("division did not finish after its last step");

   // A start taken while idle moves on to the multiply.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == P_IDLE && req.start) |=> (phase_ff == P_MUL))
      else $error("interval start was lost");

endmodule

[sv/button_press_autorepeat.sv]
// Top level of the button press autorepeat block: sequencer, action state and ports.
//
// Each request word is a latch, an update tick or a block command. Latch and block
// words are taken in the idle state and give no response. An update tick walks the
// actions one at a time through the time memory (read, evaluate, hand-off). Every
// action that repeats on the tick also waits for the interval unit (clamp, one
// multiply, a 16-step divider). Fired actions leave in index order, one response word
// each, and the last word of the tick carries rsp_last; a stalled response holds the
// walk at the next firing. A tick taken while blocked is taken in the idle state and
// fires nothing.
module button_press_autorepeat #(
   parameter int ACTIONS = bpa_pkg::ACTIONS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [bpa_pkg::OP_W-1:0]       req_op,
   input  logic [bpa_pkg::ACTION_W-1:0]   req_action,
   input  logic                           req_is_controller,
   input  logic [bpa_pkg::MASK_W-1:0]     req_held_mask,
   input  logic [bpa_pkg::MASK_W-1:0]     req_controller_mask,
   input  logic [bpa_pkg::TIME_W-1:0]     req_now_ms,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bpa_pkg::ACTION_W-1:0]   rsp_fired_action,
   output logic                           rsp_from_controller,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bpa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpa_pkg::CFG_W-1:0]      csr_data
);

   localparam int AW = (ACTIONS > 1) ? $clog2(ACTIONS) : 1;
   localparam int TW = bpa_pkg::TIME_W;
   localparam int RAM_W = 2 * TW;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_READ = 6'b000010,
      S_EVAL = 6'b000100,
      S_WAIT = 6'b001000,
      S_NEXT = 6'b010000,
      S_LAST = 6'b100000
   } state_type;

   // Configuration registers.
   logic [bpa_pkg::CFG_W-1:0]  initial_delay_ff;
   logic [bpa_pkg::CFG_W-1:0]  start_interval_ff;
   logic [bpa_pkg::CFG_W-1:0]  min_interval_ff;
   logic [bpa_pkg::CFG_W-1:0]  ramp_ff;
   logic [bpa_pkg::MASK_W-1:0] repeat_mask_ff;

   // Sequencer and per-action flag state.
   state_type                    state_ff, state_in;
   logic [AW-1:0]                idx_ff, idx_in;
   logic [ACTIONS-1:0]           prev_held_ff, prev_held_in;
   logic [ACTIONS-1:0]           latched_ff, latched_in;
   logic [ACTIONS-1:0]           latched_src_ff, latched_src_in;
   logic [ACTIONS-1:0]           entry_valid_ff, entry_valid_in;
   logic                         blocking_ff, blocking_in;

   // Captured tick word and per-action work registers.
   logic [bpa_pkg::MASK_W-1:0]   held_ff, held_in;
   logic [bpa_pkg::MASK_W-1:0]   ctrl_ff, ctrl_in;
   logic [TW-1:0]                now_ff, now_in;
   logic [TW-1:0]                press_ff, press_in;
   logic                         fire_ff, fire_in;
   logic                         src_ff, src_in;

   // Pending firing and response register.
   logic                         pend_valid_ff, pend_valid_in;
   logic [bpa_pkg::ACTION_W-1:0] pend_action_ff, pend_action_in;
   logic                         pend_src_ff, pend_src_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bpa_pkg::ACTION_W-1:0] rsp_action_ff, rsp_action_in;
   logic                         rsp_src_ff, rsp_src_in;
   logic                         rsp_last_ff, rsp_last_in;

   // Memory, interval unit and helpers.
   logic                         ram_wr_en;
   logic [RAM_W-1:0]             ram_wr_data;
   logic                         ram_rd_en;
   logic [RAM_W-1:0]             ram_rd_data;
   bpa_pkg::ival_req_type        ival_req;
   bpa_pkg::ival_rsp_type        ival_rsp;
   logic                         req_fire;
   logic                         slot_free;
   logic                         out_load;
   logic [bpa_pkg::IDX_W-1:0]    idx_wide;
   logic [TW-1:0]                rd_press;
   logic [TW-1:0]                rd_deadline;
   logic                         cur_held;
   logic                         cur_rep;
   logic                         cur_latched;
   logic                         cur_pressed;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign idx_wide  = bpa_pkg::IDX_W'(idx_ff);

   // Press time and repeat deadline of each action live in one memory word.
   bpa_ram #(
      .WIDTH (RAM_W),
      .DEPTH (ACTIONS)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   bpa_interval u_interval (
      .clock          (clock),
      .reset          (reset),
      .req            (ival_req),
      .start_interval (start_interval_ff),
      .min_interval   (min_interval_ff),
      .ramp           (ramp_ff),
      .rsp            (ival_rsp)
   );

   // Decode of the action under evaluation; a never-written entry reads as zero.
   always_comb begin
      rd_press    = entry_valid_ff[idx_ff] ? ram_rd_data[RAM_W-1:TW] : '0;
      rd_deadline = entry_valid_ff[idx_ff] ? ram_rd_data[TW-1:0] : '0;
      cur_held    = bpa_pkg::mask_bit(held_ff, idx_wide);
      cur_rep     = bpa_pkg::mask_bit(repeat_mask_ff, idx_wide);
      cur_latched = latched_ff[idx_ff];
      cur_pressed = cur_latched || (cur_held && !prev_held_ff[idx_ff]);
   end

   // Sequencer: one action at a time, so no two memory accesses overlap on an entry.
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      prev_held_in   = prev_held_ff;
      latched_in     = latched_ff;
      latched_src_in = latched_src_ff;
      entry_valid_in = entry_valid_ff;
      blocking_in    = blocking_ff;
      held_in        = held_ff;
      ctrl_in        = ctrl_ff;
      now_in         = now_ff;
      press_in       = press_ff;
      fire_in        = fire_ff;
      src_in         = src_ff;
      pend_valid_in  = pend_valid_ff;
      pend_action_in = pend_action_ff;
      pend_src_in    = pend_src_ff;
      ram_wr_en      = 1'b0;
      ram_wr_data    = '0;
      ram_rd_en      = 1'b0;
      ival_req       = '0;
      out_load       = 1'b0;
      rsp_action_in  = rsp_action_ff;
      rsp_src_in     = rsp_src_ff;
      rsp_last_in    = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  bpa_pkg::OP_LATCH: begin
                     for (int i = 0; i < ACTIONS; i++) begin
                        if (bpa_pkg::IDX_W'(req_action) == bpa_pkg::IDX_W'(i)) begin
                           latched_in[i]     = 1'b1;
                           latched_src_in[i] = req_is_controller;
                        end
                     end
                  end
                  bpa_pkg::OP_BLOCK: begin
                     blocking_in = 1'b1;
                  end
                  bpa_pkg::OP_UPDATE: begin
                     if (blocking_ff) begin
                        // Discard the tick; leave blocking once nothing is held.
                        for (int i = 0; i < ACTIONS; i++) begin
                           prev_held_in[i] =
                              bpa_pkg::mask_bit(req_held_mask, bpa_pkg::IDX_W'(i));
                        end
                        latched_in = '0;
                        if (req_held_mask == '0) begin
                           blocking_in = 1'b0;
                        end
                     end else begin
                        held_in  = req_held_mask;
                        ctrl_in  = req_controller_mask;
                        now_in   = req_now_ms;
                        idx_in   = '0;
                        state_in = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            ram_rd_en = 1'b1;
            state_in  = S_EVAL;
         end
         S_EVAL: begin
            src_in   = cur_latched ? latched_src_ff[idx_ff] : bpa_pkg::mask_bit(ctrl_ff, idx_wide);
            press_in = rd_press;
            latched_in[idx_ff]   = 1'b0;
            prev_held_in[idx_ff] = cur_held;
            if (cur_pressed) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = {now_ff, cur_rep ? (now_ff + TW'(initial_delay_ff)) : TW'(0)};
               entry_valid_in[idx_ff] = 1'b1;
               fire_in  = 1'b1;
               state_in = S_NEXT;
            end else if (cur_held && cur_rep && (now_ff >= rd_deadline)) begin
               ival_req.start = 1'b1;
               ival_req.now   = now_ff;
               ival_req.since = rd_press;
               fire_in  = 1'b1;
               state_in = S_WAIT;
            end else begin
               fire_in  = 1'b0;
               state_in = S_NEXT;
            end
         end
         S_WAIT: begin
            if (ival_rsp.done) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = {press_ff, now_ff + TW'(ival_rsp.interval)};
               entry_valid_in[idx_ff] = 1'b1;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            // A firing is held back until the next one shows it is not the last.
            if (!fire_ff || !pend_valid_ff || slot_free) begin
               if (fire_ff) begin
                  if (pend_valid_ff) begin
                     out_load      = 1'b1;
                     rsp_action_in = pend_action_ff;
                     rsp_src_in    = pend_src_ff;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_action_in = bpa_pkg::ACTION_W'(idx_ff);
                  pend_src_in    = src_ff;
               end
               if (idx_ff == AW'(ACTIONS - 1)) begin
                  state_in = S_LAST;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_LAST: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (slot_free) begin
               out_load      = 1'b1;
               rsp_action_in = pend_action_ff;
               rsp_src_in    = pend_src_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         idx_ff         <= '0;
         prev_held_ff   <= '0;
         latched_ff     <= '0;
         latched_src_ff <= '0;
         entry_valid_ff <= '0;
         blocking_ff    <= 1'b1;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         prev_held_ff   <= prev_held_in;
         latched_ff     <= latched_in;
         latched_src_ff <= latched_src_in;
         entry_valid_ff <= entry_valid_in;
         blocking_ff    <= blocking_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      held_ff        <= held_in;
      ctrl_ff        <= ctrl_in;
      now_ff         <= now_in;
      press_ff       <= press_in;
      fire_ff        <= fire_in;
      src_ff         <= src_in;
      pend_action_ff <= pend_action_in;
      pend_src_ff    <= pend_src_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_src_ff     <= rsp_src_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         initial_delay_ff  <= bpa_pkg::INITIAL_DELAY_RESET;
         start_interval_ff <= bpa_pkg::START_INTERVAL_RESET;
         min_interval_ff   <= bpa_pkg::MIN_INTERVAL_RESET;
         ramp_ff           <= bpa_pkg::RAMP_RESET;
         repeat_mask_ff    <= bpa_pkg::REPEAT_MASK_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bpa_pkg::CSR_INITIAL_DELAY:  initial_delay_ff  <= csr_data;
            bpa_pkg::CSR_START_INTERVAL: start_interval_ff <= csr_data;
            bpa_pkg::CSR_MIN_INTERVAL:   min_interval_ff   <= csr_data;
            bpa_pkg::CSR_RAMP:           ramp_ff           <= csr_data;
            bpa_pkg::CSR_REPEAT_MASK:    repeat_mask_ff    <= csr_data[bpa_pkg::MASK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_fired_action    = rsp_action_ff;
   assign rsp_from_controller = rsp_src_ff;
   assign rsp_last            = rsp_last_ff;

   // A block word always leaves the block in blocking mode.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_op == bpa_pkg::OP_BLOCK) |=> blocking_ff)
      else $error("block word did not set blocking");

   // No firing is left behind when a tick is finished.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("pending firing left at end of tick");

   // The walk never steps past the last action.
   assert property (@(posedge clock) disable iff (reset) idx_ff <= AW'(ACTIONS - 1))
      else $error("action index out of range");

   // A new response word never overwrites one that has not been taken.
   assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response word overwritten");

endmodule

[tb/sv/button_press_autorepeat_tb.sv]
// Self-checking testbench for the button press autorepeat block.
module button_press_autorepeat_tb;

   // Operation code that the block leaves unused.
   localparam logic [bpa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   // Cycles to let the block finish a tick that fires nothing (an 8-action walk).
   localparam int SETTLE_CYCLES = 200;
   // Cycles without any handshake before the run is declared hung.
   localparam int QUIET_LIMIT   = 4000;
   // Length of the long receiver hold-off and the request count that starts it.
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_AFTER    = 120;
   // Items per configuration phase in the random part.
   localparam int PHASE_ITEMS   = 58;

   // One request word as offered to the block.
   typedef struct packed {
      logic [bpa_pkg::OP_W-1:0]     op;
      logic [bpa_pkg::ACTION_W-1:0] action;
      logic                         is_controller;
      logic [bpa_pkg::MASK_W-1:0]   held_mask;
      logic [bpa_pkg::MASK_W-1:0]   controller_mask;
      logic [bpa_pkg::TIME_W-1:0]   now_ms;
   } press_req_type;

   // One response word: a fired action.
   typedef struct packed {
      logic [bpa_pkg::ACTION_W-1:0] action;
      logic                         from_controller;
      logic                         is_last;
   } firing_type;

   // Tracks the press and repeat state of every action and predicts the firings of each tick.
   class scoreboard_type;
      bit [15:0]  delay_ms;
      bit [15:0]  start_ms;
      bit [15:0]  min_ms;
      bit [15:0]  ramp_len;
      bit [7:0]   repeat_bits;
      bit [7:0]   prev_held;
      bit [7:0]   latched;
      bit [7:0]   latch_src;
      bit [31:0]  press_at [8];
      bit [31:0]  deadline [8];
      bit         blocked;
      firing_type expected_firings [$];
      int         failures;

      function new();
         delay_ms    = bpa_pkg::INITIAL_DELAY_RESET;
         start_ms    = bpa_pkg::START_INTERVAL_RESET;
         min_ms      = bpa_pkg::MIN_INTERVAL_RESET;
         ramp_len    = bpa_pkg::RAMP_RESET;
         repeat_bits = bpa_pkg::REPEAT_MASK_RESET;
         prev_held   = '0;
         latched     = '0;
         latch_src   = '0;
         blocked     = 1'b1;
         failures    = 0;
         for (int i = 0; i < 8; i++) begin
            press_at[i] = '0;
            deadline[i] = '0;
         end
      endfunction

      function void set_register(logic [bpa_pkg::CSR_IDX_W-1:0] idx,
                                 logic [bpa_pkg::CFG_W-1:0] data);
         case (idx)
            bpa_pkg::CSR_INITIAL_DELAY:  delay_ms = data;
            bpa_pkg::CSR_START_INTERVAL: start_ms = data;
            bpa_pkg::CSR_MIN_INTERVAL:   min_ms = data;
            bpa_pkg::CSR_RAMP:           ramp_len = data;
            bpa_pkg::CSR_REPEAT_MASK:    repeat_bits = data[7:0];
            default: ;
         endcase
      endfunction

      // Linear ramp of the repeat interval; signed division truncates toward zero.
      function bit [31:0] ramp_gap_ms(bit [31:0] now, bit [31:0] since);
         longint hold_span;
         longint span;
         longint result;
         if (ramp_len == 0) return 32'(min_ms);
         hold_span = longint'(now) - longint'(since);
         if (hold_span < 0) hold_span = 0;
         if (hold_span > longint'(ramp_len)) hold_span = longint'(ramp_len);
         span = longint'(min_ms) - longint'(start_ms);
         result = longint'(start_ms) + (span * hold_span) / longint'(ramp_len);
         return result[31:0];
      endfunction

      function void note_request(press_req_type r);
         bit         held_bit;
         bit         rep;
         bit         pressed;
         bit         fire;
         bit         src;
         bit         have_prev;
         firing_type prev;
         have_prev = 1'b0;
         prev = '0;
         case (r.op)
            bpa_pkg::OP_LATCH: begin
               latched[r.action] = 1'b1;
               latch_src[r.action] = r.is_controller;
            end
            bpa_pkg::OP_BLOCK: blocked = 1'b1;
            bpa_pkg::OP_UPDATE: begin
               if (blocked) begin
                  // While blocked a tick only tracks the held keys and drops latches.
                  prev_held = r.held_mask;
                  latched = '0;
                  if (r.held_mask == 0) blocked = 1'b0;
               end else begin
                  for (int i = 0; i < 8; i++) begin
                     held_bit = r.held_mask[i];
                     rep = repeat_bits[i];
                     pressed = latched[i] || (held_bit && !prev_held[i]);
                     fire = pressed;
                     if (pressed) begin
                        press_at[i] = r.now_ms;
                        deadline[i] = rep ? r.now_ms + 32'(delay_ms) : 32'd0;
                     end else if (held_bit && rep && r.now_ms >= deadline[i]) begin
                        fire = 1'b1;
                        deadline[i] = r.now_ms + ramp_gap_ms(r.now_ms, press_at[i]);
                     end
                     src = latched[i] ? latch_src[i] : r.controller_mask[i];
                     latched[i] = 1'b0;
                     prev_held[i] = held_bit;
                     if (fire) begin
                        if (have_prev) expected_firings.push_back(prev);
                        prev.action = bpa_pkg::ACTION_W'(i);
                        prev.from_controller = src;
                        prev.is_last = 1'b0;
                        have_prev = 1'b1;
                     end
                  end
                  // The final firing of the tick carries the last flag.
                  if (have_prev) begin
                     prev.is_last = 1'b1;
                     expected_firings.push_back(prev);
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void check_firing(logic [bpa_pkg::ACTION_W-1:0] action, logic from_ctrl,
                                 logic is_last);
         firing_type want;
         if (expected_firings.size() == 0) begin
            $error("unexpected response word: fired_action %0d", action);
            failures++;
            return;
         end
         want = expected_firings.pop_front();
         if (action !== want.action) begin
            $error("fired_action: expected %0d, got %0d", want.action, action);
            failures++;
         end
         if (from_ctrl !== want.from_controller) begin
            $error("from_controller: expected %0d, got %0d", want.from_controller, from_ctrl);
            failures++;
         end
         if (is_last !== want.is_last) begin
            $error("last: expected %0d, got %0d", want.is_last, is_last);
            failures++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [bpa_pkg::OP_W-1:0]      req_op = '0;
   logic [bpa_pkg::ACTION_W-1:0]  req_action = '0;
   logic                          req_is_controller = 1'b0;
   logic [bpa_pkg::MASK_W-1:0]    req_held_mask = '0;
   logic [bpa_pkg::MASK_W-1:0]    req_controller_mask = '0;
   logic [bpa_pkg::TIME_W-1:0]    req_now_ms = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [bpa_pkg::ACTION_W-1:0]  rsp_fired_action;
   logic                          rsp_from_controller;
   logic                          rsp_last;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [bpa_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bpa_pkg::CFG_W-1:0]     csr_data = '0;

   scoreboard_type board = new();

   // Sender-side stimulus state: keys held, controller keys and the running clock in ms.
   bit [7:0]  held_state = '0;
   bit [7:0]  ctrl_state = '0;
   bit [31:0] clock_ms = 32'd1000;
   int        items_sent = 0;
   bit        calm = 1'b0;

   // Receiver and watchdog state.
   int        req_taken = 0;
   int        hold_left = 0;
   bit        hold_done = 1'b0;
   int        quiet = 0;

   button_press_autorepeat DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_action          (req_action),
      .req_is_controller   (req_is_controller),
      .req_held_mask       (req_held_mask),
      .req_controller_mask (req_controller_mask),
      .req_now_ms          (req_now_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_fired_action    (rsp_fired_action),
      .rsp_from_controller (rsp_from_controller),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #6 clock = ~clock;

   function automatic press_req_type request(logic [bpa_pkg::OP_W-1:0] op,
                                             logic [bpa_pkg::ACTION_W-1:0] action,
                                             logic src, logic [bpa_pkg::MASK_W-1:0] held,
                                             logic [bpa_pkg::MASK_W-1:0] ctrl,
                                             logic [bpa_pkg::TIME_W-1:0] now);
      press_req_type r;
      r.op = op;
      r.action = action;
      r.is_controller = src;
      r.held_mask = held;
      r.controller_mask = ctrl;
      r.now_ms = now;
      return r;
   endfunction

   // Offer one request word after an optional random gap and wait until it is taken.
   task automatic offer(press_req_type r);
      while (!calm && $urandom_range(0, 99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_op <= r.op;
      req_action <= r.action;
      req_is_controller <= r.is_controller;
      req_held_mask <= r.held_mask;
      req_controller_mask <= r.controller_mask;
      req_now_ms <= r.now_ms;
      req_valid <= 1'b1;
      items_sent++;
      calm <= (items_sent >= 160 && items_sent < 230);
      do @(posedge clock); while (req_stall);
   endtask

   // Write one register; the caller lowers csr_valid after the last write.
   task automatic write_register(logic [bpa_pkg::CSR_IDX_W-1:0] idx,
                                 logic [bpa_pkg::CFG_W-1:0] data);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Stop offering, wait for every predicted firing, then let a silent tick finish.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_firings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly realistic key activity with random content, plus latches, blocks and noise.
   task automatic run_phase(int count, int unsigned step_max);
      press_req_type r;
      int unsigned   pick;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         r = request(bpa_pkg::OP_UPDATE, bpa_pkg::ACTION_W'($urandom), 1'($urandom),
                     bpa_pkg::MASK_W'($urandom), bpa_pkg::MASK_W'($urandom), $urandom);
         if (pick < 58) begin
            held_state ^= 8'($urandom & $urandom & $urandom);
            ctrl_state ^= 8'($urandom & $urandom & $urandom & $urandom);
            clock_ms += $urandom_range(0, step_max);
            r.held_mask = held_state;
            r.controller_mask = ctrl_state;
            r.now_ms = clock_ms;
         end else if (pick < 76) begin
            r.op = bpa_pkg::OP_LATCH;
         end else if (pick < 79) begin
            r.op = bpa_pkg::OP_BLOCK;
         end else if (pick < 86) begin
            // Release of every key, which also ends a block.
            held_state = '0;
            clock_ms += $urandom_range(0, step_max);
            r.held_mask = '0;
            r.now_ms = clock_ms;
         end else if (pick < 92) begin
            // Jump of the clock, often to just below the wrap point.
            if ($urandom_range(0, 1) == 1) begin
               r.now_ms = 32'hFFFF_FFFF - $urandom_range(0, step_max * 4);
            end
            clock_ms = r.now_ms;
            r.held_mask = held_state;
         end else begin
            r.op = bpa_pkg::OP_W'($urandom);
         end
         offer(r);
      end
   endtask

   // Monitor: feed accepted words to the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            board.note_request(request(req_op, req_action, req_is_controller, req_held_mask,
                                       req_controller_mask, req_now_ms));
            req_taken <= req_taken + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            board.check_firing(rsp_fired_action, rsp_from_controller, rsp_last);
         end
         if (csr_valid && csr_ready) begin
            board.set_register(csr_index, csr_data);
         end
      end
   end

   // Receiver: random stalls, one long hold-off so the block backs up into its input.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && req_taken >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 19);
      end
   end

   // Watchdog: end the run if no word moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      bit [15:0]   delay_cfg;
      bit [15:0]   start_cfg;
      bit [15:0]   min_cfg;
      bit [15:0]   ramp_cfg;
      bit [7:0]    mask_cfg;
      int unsigned step_max;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset settings: block comes out of reset active.
      offer(request(bpa_pkg::OP_UPDATE, 3'd0, 1'b0, 8'h05, 8'h00, 32'd100));
      offer(request(bpa_pkg::OP_LATCH, 3'd3, 1'b1, 8'h00, 8'h00, 32'd0));
      offer(request(bpa_pkg::OP_UPDATE, 3'd0, 1'b0, 8'h00, 8'hFF, 32'd110));
      offer(request(OP_UNUSED, 3'd7, 1'b1, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
      offer(request(bpa_pkg::OP_LATCH, 3'd7, 1'b1, 8'h00, 8'h00, 32'd0));
      offer(request(bpa_pkg::OP_LATCH, 3'd0, 1'b0, 8'h00, 8'h00, 32'd0));
      // Every action fires at once; latched ones keep their latched source.
      offer(request(bpa_pkg::OP_UPDATE, 3'd0, 1'b0, 8'hFF, 8'hAA, 32'd200));
      offer(request(bpa_pkg::OP_UPDATE, 3'd0, 1'b0, 8'hFF, 8'h55, 32'd519));
      offer(request(bpa_pkg::OP_UPDATE, 3'd0, 1'b0, 8'hFF, 8'h55, 32'd520));
      // Time going backward before the deadline.
      offer(request(bpa_pkg::OP_UPDATE, 3'd0, 1'b0, 8'h0F, 8'h00, 32'd300));
      offer(request(bpa_pkg::OP_UPDATE, 3'd0, 1'b0, 8'h00, 8'h00, 32'd600));
      // Press just below the wrap point, so the deadline wraps past zero.
      offer(request(bpa_pkg::OP_UPDATE, 3'd0, 1'b0, 8'h01, 8'h01, 32'hFFFF_FFF0));
      offer(request(bpa_pkg::OP_UPDATE, 3'd0, 1'b0, 8'h01, 8'h00, 32'h0000_0200));
      offer(request(bpa_pkg::OP_UPDATE, 3'd0, 1'b0, 8'h01, 8'h00, 32'hFFFF_FFFF));
      // Block, then ticks that only end it once every key is released.
      offer(request(bpa_pkg::OP_BLOCK, 3'd0, 1'b0, 8'h00, 8'h00, 32'd0));
      offer(request(bpa_pkg::OP_UPDATE, 3'd0, 1'b0, 8'h03, 8'h00, 32'h0000_1000));
      offer(request(bpa_pkg::OP_UPDATE, 3'd0, 1'b0, 8'h02, 8'h00, 32'h0000_1010));
      offer(request(bpa_pkg::OP_UPDATE, 3'd0, 1'b0, 8'h00, 8'h00, 32'h0000_1020));
      // Non-repeatable action: fires on press only.
      offer(request(bpa_pkg::OP_UPDATE, 3'd0, 1'b0, 8'h80, 8'h80, 32'h0000_2000));
      offer(request(bpa_pkg::OP_UPDATE, 3'd0, 1'b0, 8'h80, 8'h00, 32'h0000_3000));
      // A latch fires even with nothing held.
      offer(request(bpa_pkg::OP_LATCH, 3'd5, 1'b0, 8'h00, 8'h00, 32'd0));
      offer(request(bpa_pkg::OP_UPDATE, 3'd0, 1'b0, 8'h00, 8'hFF, 32'h0000_3001));
      offer(request(bpa_pkg::OP_UPDATE, 3'd0, 1'b0, 8'h00, 8'h00, 32'd0));

      // Random part, one register setting per phase, extremes first.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               delay_cfg = 16'd0; start_cfg = 16'd1; min_cfg = 16'd1;
               ramp_cfg = 16'd1; mask_cfg = 8'hFF;
            end
            1: begin
               delay_cfg = 16'hFFFF; start_cfg = 16'hFFFF; min_cfg = 16'd1;
               ramp_cfg = 16'hFFFF; mask_cfg = 8'hF0;
            end
            2: begin
               delay_cfg = 16'd30; start_cfg = 16'd1; min_cfg = 16'hFFFF;
               ramp_cfg = 16'd200; mask_cfg = 8'h5A;
            end
            3: begin
               delay_cfg = 16'($urandom_range(0, 600)); start_cfg = 16'($urandom_range(1, 300));
               min_cfg = 16'($urandom_range(1, 300)); ramp_cfg = 16'($urandom_range(1, 3000));
               mask_cfg = 8'h00;
            end
            4: begin
               delay_cfg = 16'($urandom_range(0, 600)); start_cfg = 16'($urandom_range(1, 300));
               min_cfg = 16'($urandom_range(1, 300)); ramp_cfg = 16'($urandom_range(1, 3000));
               mask_cfg = 8'($urandom);
            end
            default: begin
               delay_cfg = 16'($urandom); start_cfg = 16'($urandom_range(1, 65535));
               min_cfg = 16'($urandom_range(1, 65535));
               ramp_cfg = 16'($urandom_range(1, 65535));
               mask_cfg = 8'($urandom);
            end
         endcase

         drain();
         write_register(bpa_pkg::CSR_INITIAL_DELAY, delay_cfg);
         write_register(bpa_pkg::CSR_START_INTERVAL, start_cfg);
         write_register(bpa_pkg::CSR_MIN_INTERVAL, min_cfg);
         write_register(bpa_pkg::CSR_RAMP, ramp_cfg);
         write_register(bpa_pkg::CSR_REPEAT_MASK, bpa_pkg::CFG_W'(mask_cfg));
         csr_valid <= 1'b0;

         // Tick spacing follows the slowest timing in use so repeats stay reachable.
         step_max = delay_cfg;
         if (start_cfg > step_max) step_max = start_cfg;
         if (min_cfg > step_max) step_max = min_cfg;
         step_max = step_max / 3 + 4;
         run_phase(PHASE_ITEMS, step_max);
      end

      drain();
      if (board.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
